// ===== rtl/ttgwg_pkg.sv =====
package ttgwg_pkg;

  localparam int CordicIters = 16;
  localparam int IterCount = (CordicIters > 24) ? 24 : CordicIters;
  localparam int IterW = $clog2(IterCount + 1);

  localparam logic signed [15:0] PiQ12 = 16'sd12868;
  localparam logic signed [15:0] TwoPiQ12 = 16'sd25736;
  localparam logic signed [27:0] PiA24 = 28'sd52707179;
  localparam logic signed [17:0] YawSat = 18'sd16384;

  typedef enum logic [1:0] {
    STAGE_TURN = 2'd0,
    STAGE_GO = 2'd1,
    STAGE_HOLD = 2'd2
  } stage_t;

  typedef enum logic [2:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_D = 3'd1,
    REG_CRUISE = 3'd2,
    REG_ALIGNED = 3'd3,
    REG_ARRIVE = 3'd4,
    REG_DEPART = 3'd5,
    REG_YAW_LIMIT = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ITER,
    SEQ_ERR,
    SEQ_PD,
    SEQ_OUT
  } seq_t;

  // arctan(2^-i) at 2^-24 rad
  function automatic logic signed [27:0] atan_entry(input logic [4:0] i);
    logic signed [27:0] v;
    case (i)
      5'd0: v = 28'sd13176795;
      5'd1: v = 28'sd7778716;
      5'd2: v = 28'sd4110060;
      5'd3: v = 28'sd2086331;
      5'd4: v = 28'sd1047214;
      5'd5: v = 28'sd524117;
      5'd6: v = 28'sd262123;
      5'd7: v = 28'sd131069;
      default: v = 28'sd65536 >>> (i - 5'd8);
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ttgwg_isqrt.sv =====
// Rounded integer square root of a 33-bit value, one result bit per cycle.
module ttgwg_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] radicand,
  output logic        done,
  output logic [16:0] root
);
  logic [33:0] rem;
  logic [33:0] r;
  logic [33:0] bitv;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] rem_next;
  logic [33:0] r_next;

  // r carries the partial root scaled by the current bit weight
  assign trial = r + bitv;

  always_comb begin
    rem_next = rem;
    r_next = r >> 1;
    if (rem >= trial) begin
      rem_next = rem - trial;
      r_next = (r >> 1) + bitv;
    end
  end

  // restoring square root over 17 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= {1'b0, radicand};
        r <= '0;
        bitv <= 34'd1 << 32;
      end else if (busy) begin
        rem <= rem_next;
        r <= r_next;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round to nearest: remainder is s - r^2
  assign root = (rem > r) ? r[16:0] + 17'd1 : r[16:0];
endmodule

// ===== rtl/turn_then_go_waypoint_guidance.sv =====
// Turn-then-go waypoint guidance. An accepted item first latches its offset, then
// runs 16 CORDIC iterations plus a closing pass on the shared stage with the 17-step
// square root running beside it, then heading error, PD and stage update, before its
// result beat. The block takes no item meanwhile, and the result register holds one
// beat until taken, so a new item is accepted only after the last result is taken.
// The configuration port is always ready; write it only while no item is in flight.
module turn_then_go_waypoint_guidance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] goal_east,
  input  logic signed [15:0] goal_north,
  input  logic signed [15:0] pos_east,
  input  logic signed [15:0] pos_north,
  input  logic signed [14:0] heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        forward_speed,
  output logic signed [15:0] yaw_cmd,
  output logic [1:0]         stage_now,
  output logic [16:0]        goal_distance,
  output logic signed [14:0] bearing_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  // configuration
  logic [15:0] gain_p, gain_d, cruise, arrive, depart;
  logic [13:0] aligned;
  logic [14:0] yaw_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= 16'd4096;
      gain_d <= 16'd205;
      cruise <= 16'd102;
      aligned <= 14'd410;
      arrive <= 16'd128;
      depart <= 16'd256;
      yaw_limit <= 15'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttgwg_pkg::REG_GAIN_P:    gain_p <= cfg_data;
        ttgwg_pkg::REG_GAIN_D:    gain_d <= cfg_data;
        ttgwg_pkg::REG_CRUISE:    cruise <= cfg_data;
        ttgwg_pkg::REG_ALIGNED:   aligned <= cfg_data[13:0];
        ttgwg_pkg::REG_ARRIVE:    arrive <= cfg_data;
        ttgwg_pkg::REG_DEPART:    depart <= cfg_data;
        ttgwg_pkg::REG_YAW_LIMIT: yaw_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // sequencer
  ttgwg_pkg::seq_t seq, seq_next;
  ttgwg_pkg::stage_t stage;
  logic signed [14:0] prev_err;
  logic [15:0] prev_ge, prev_gn;

  logic signed [16:0] de, dn;
  logic signed [16:0] de_in, dn_in;
  logic signed [14:0] head;
  logic [15:0] ge_r, gn_r;
  logic signed [27:0] cx, cy, cz;
  logic [ttgwg_pkg::IterW-1:0] iter;
  logic zero_off;
  logic signed [15:0] err;
  logic signed [34:0] pd_sum;
  logic sq_start, sq_done, sq_seen;
  logic [16:0] sq_root;
  logic [32:0] radicand;
  logic in_take;
  logic loaded;

  assign in_stall = (seq != ttgwg_pkg::SEQ_IDLE) || out_valid;
  assign in_take = in_valid && !in_stall;

  assign de_in = 17'(goal_east) - 17'(pos_east);
  assign dn_in = 17'(goal_north) - 17'(pos_north);

  // square root starts once the offset is latched
  assign sq_start = loaded;
  assign radicand = {1'b0, 32'(de * de)} + {1'b0, 32'(dn * dn)};

  ttgwg_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(radicand),
    .done(sq_done), .root(sq_root)
  );

  // shared CORDIC stage
  logic signed [27:0] xs, ys, xn, yn, zn;
  logic signed [27:0] ang;
  assign xs = cx >>> iter;
  assign ys = cy >>> iter;
  assign ang = ttgwg_pkg::atan_entry(5'(iter));
  always_comb begin
    if (cy > 0) begin
      xn = cx + ys; yn = cy - xs; zn = cz + ang;
    end else begin
      xn = cx - ys; yn = cy + xs; zn = cz - ang;
    end
  end

  // bearing: round half up then clamp
  logic signed [27:0] zr;
  logic signed [15:0] braw, bw, hw;
  logic signed [16:0] ediff;
  assign zr = (cz + 28'sd2048) >>> 12;
  always_comb begin
    if (zero_off) braw = '0;
    else if (zr > 28'(ttgwg_pkg::PiQ12)) braw = ttgwg_pkg::PiQ12;
    else if (zr < -28'(ttgwg_pkg::PiQ12)) braw = -ttgwg_pkg::PiQ12;
    else braw = 16'(zr);
    bw = (braw < 0) ? braw + ttgwg_pkg::TwoPiQ12 : braw;
    hw = (head < 0) ? 16'(head) + ttgwg_pkg::TwoPiQ12 : 16'(head);
    ediff = 17'(bw) - 17'(hw);
    if (ediff > 17'(ttgwg_pkg::PiQ12)) ediff = ediff - 17'(ttgwg_pkg::TwoPiQ12);
    else if (ediff < -17'(ttgwg_pkg::PiQ12)) ediff = ediff + 17'(ttgwg_pkg::TwoPiQ12);
  end

  // PD result rounding and stage logic
  logic signed [34:0] sr;
  logic signed [17:0] sat;
  logic signed [17:0] yaw_o;
  logic [15:0] spd_o;
  ttgwg_pkg::stage_t stage_next;
  logic [15:0] abs_err;
  logic moved;
  assign sr = (pd_sum + 35'sd2048) >>> 12;
  assign abs_err = err[15] ? 16'(-err) : 16'(err);
  assign moved = (ge_r != prev_ge) || (gn_r != prev_gn);
  always_comb begin
    if (sr > 35'(ttgwg_pkg::YawSat)) sat = ttgwg_pkg::YawSat;
    else if (sr < -35'(ttgwg_pkg::YawSat)) sat = -ttgwg_pkg::YawSat;
    else sat = 18'(sr);
    yaw_o = '0;
    spd_o = '0;
    stage_next = stage;
    case (stage)
      ttgwg_pkg::STAGE_TURN: begin
        yaw_o = sat;
        if (abs_err < {2'b0, aligned}) stage_next = ttgwg_pkg::STAGE_GO;
      end
      ttgwg_pkg::STAGE_GO: begin
        spd_o = cruise;
        yaw_o = sat;
        if (sat > $signed({3'b0, yaw_limit})) yaw_o = $signed({3'b0, yaw_limit});
        if (sat < -$signed({3'b0, yaw_limit})) yaw_o = -$signed({3'b0, yaw_limit});
        if (sq_root < {1'b0, arrive}) stage_next = ttgwg_pkg::STAGE_HOLD;
      end
      default: begin
        if (sq_root > {1'b0, depart} && moved) stage_next = ttgwg_pkg::STAGE_TURN;
      end
    endcase
  end

  // next state
  always_comb begin
    seq_next = seq;
    case (seq)
      ttgwg_pkg::SEQ_IDLE: if (in_take) seq_next = ttgwg_pkg::SEQ_ITER;
      ttgwg_pkg::SEQ_ITER:
        if (iter == ttgwg_pkg::IterW'(ttgwg_pkg::IterCount)) seq_next = ttgwg_pkg::SEQ_ERR;
      ttgwg_pkg::SEQ_ERR: seq_next = ttgwg_pkg::SEQ_PD;
      ttgwg_pkg::SEQ_PD: if (sq_done || sq_seen) seq_next = ttgwg_pkg::SEQ_OUT;
      ttgwg_pkg::SEQ_OUT: seq_next = ttgwg_pkg::SEQ_IDLE;
      default: seq_next = ttgwg_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= ttgwg_pkg::SEQ_IDLE;
      stage <= ttgwg_pkg::STAGE_TURN;
      prev_err <= '0;
      prev_ge <= '0;
      prev_gn <= '0;
      out_valid <= 1'b0;
      sq_seen <= 1'b0;
    end else begin
      seq <= seq_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (sq_done) sq_seen <= 1'b1;
      case (seq)
        ttgwg_pkg::SEQ_IDLE: begin
          sq_seen <= 1'b0;
          if (in_take) begin
            de <= de_in;
            dn <= dn_in;
            head <= heading;
            ge_r <= goal_east;
            gn_r <= goal_north;
            iter <= '0;
            // CORDIC setup with pre-rotation into right half-plane
            if (dn_in < 0) begin
              cx <= -(28'(dn_in) <<< 8);
              cy <= -(28'(de_in) <<< 8);
              cz <= (de_in >= 0) ? ttgwg_pkg::PiA24 : -ttgwg_pkg::PiA24;
            end else begin
              cx <= 28'(dn_in) <<< 8;
              cy <= 28'(de_in) <<< 8;
              cz <= '0;
            end
          end
        end
        ttgwg_pkg::SEQ_ITER: begin
          iter <= iter + 1'b1;
          if (iter != ttgwg_pkg::IterW'(ttgwg_pkg::IterCount)) begin
            cx <= xn; cy <= yn; cz <= zn;
          end
        end
        ttgwg_pkg::SEQ_ERR: begin
          err <= 16'(ediff);
        end
        ttgwg_pkg::SEQ_PD: begin
          pd_sum <= 35'(err) * $signed({1'b0, gain_p})
                  + 35'(17'(err) - 17'(prev_err)) * $signed({1'b0, gain_d});
        end
        ttgwg_pkg::SEQ_OUT: begin
          stage <= stage_next;
          prev_err <= 15'(err);
          prev_ge <= ge_r;
          prev_gn <= gn_r;
          forward_speed <= spd_o;
          yaw_cmd <= 16'(yaw_o);
          stage_now <= stage_next;
          goal_distance <= sq_root;
          bearing_error <= 15'(err);
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // square root start pulses in the cycle after accept
  always_ff @(posedge clk) begin
    if (rst) loaded <= 1'b0;
    else loaded <= in_take;
  end
  always_comb zero_off = (de == 0) && (dn == 0);
endmodule
